FILE: rtl/hcmm_pkg.sv
// ----------------------------------------------------------------------------
// hcmm_pkg: handheld console memory map package
// Request codes, region codes, map constants and the address decoder.
// ----------------------------------------------------------------------------
package hcmm_pkg;

  localparam int BOOT_SIZE  = 256;
  localparam int ROM_SIZE   = 32768;
  localparam int BANK_BYTES = 4096;

  localparam logic [15:0] ADDR_RAM_BASE   = 16'h8000;
  localparam logic [15:0] ADDR_ERAM_BASE  = 16'hA000;
  localparam logic [15:0] ADDR_WRAM0_BASE = 16'hC000;
  localparam logic [15:0] ADDR_WRAMX_BASE = 16'hD000;
  localparam logic [15:0] ADDR_ECHO_BASE  = 16'hE000;
  localparam logic [15:0] ADDR_ECHO_SHIFT = 16'h2000;
  localparam logic [15:0] ADDR_OAM_BASE   = 16'hFE00;
  localparam logic [15:0] ADDR_UNUS_BASE  = 16'hFEA0;
  localparam logic [15:0] ADDR_IO_BASE    = 16'hFF00;
  localparam logic [15:0] ADDR_HRAM_BASE  = 16'hFF80;
  localparam logic [15:0] ADDR_IE         = 16'hFFFF;
  localparam logic [15:0] ADDR_BOOT_OFF   = 16'hFF50;
  localparam logic [15:0] ADDR_WRAM_BANK  = 16'hFF70;
  localparam logic [7:0]  UNUS_OFFSET     = 8'hA0;

  typedef enum logic [1:0] {
    REQ_READ      = 2'd0,
    REQ_WRITE     = 2'd1,
    REQ_LOAD_ROM  = 2'd2,
    REQ_LOAD_BOOT = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    RGN_BOOT,
    RGN_ROM,
    RGN_VRAM,
    RGN_ERAM,
    RGN_WRAM0,
    RGN_WRAMX,
    RGN_OAM,
    RGN_UNUS,
    RGN_IO,
    RGN_HRAM,
    RGN_IE
  } region_t;

  // Bus address to region; echo space folds onto work RAM.
  function automatic region_t bus_region(logic [15:0] addr, logic overlay);
    logic [15:0] fold;
    region_t     rgn;
    fold = addr;
    if (addr >= ADDR_ECHO_BASE && addr < ADDR_OAM_BASE) begin
      fold = addr - ADDR_ECHO_SHIFT;
    end
    if (addr < ADDR_RAM_BASE) begin
      rgn = (overlay && addr < 16'(BOOT_SIZE)) ? RGN_BOOT : RGN_ROM;
    end else if (fold < ADDR_ERAM_BASE) begin
      rgn = RGN_VRAM;
    end else if (fold < ADDR_WRAM0_BASE) begin
      rgn = RGN_ERAM;
    end else if (fold < ADDR_WRAMX_BASE) begin
      rgn = RGN_WRAM0;
    end else if (fold < ADDR_ECHO_BASE) begin
      rgn = RGN_WRAMX;
    end else if (fold < ADDR_UNUS_BASE) begin
      rgn = RGN_OAM;
    end else if (fold < ADDR_IO_BASE) begin
      rgn = RGN_UNUS;
    end else if (fold < ADDR_HRAM_BASE) begin
      rgn = RGN_IO;
    end else if (fold < ADDR_IE) begin
      rgn = RGN_HRAM;
    end else begin
      rgn = RGN_IE;
    end
    return rgn;
  endfunction

endpackage

FILE: rtl/handheld_console_memory_map.sv
// ----------------------------------------------------------------------------
// handheld_console_memory_map: bus memory map of an 8-bit handheld console
// Decodes 16-bit bus reads and writes onto ROM, boot overlay and RAM regions,
// and takes load beats that fill the ROM and boot images.
// ----------------------------------------------------------------------------
// Usage: one request beat per cycle in while in_stall is low, one result beat
// per request out. At accept the request address goes straight into the
// single-port RAMs and the read data is registered there; the region mux then
// lands in the output register, which drives out_valid. A write is seen by a
// read accepted in the very next cycle, bank switches and the boot overlay
// switch-off included. After reset a clearing pass zeroes every store, one
// entry per cycle in all RAMs at once, with in_stall held high meanwhile. ROM
// writes on the bus return status 1.
// ----------------------------------------------------------------------------
module handheld_console_memory_map #(
  parameter int WRAM_BANKS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_status
);

  localparam int WramxDepth = WRAM_BANKS * hcmm_pkg::BANK_BYTES;
  localparam int WramxAw    = $clog2(WramxDepth);
  localparam int RomAw      = $clog2(hcmm_pkg::ROM_SIZE);
  localparam int BootAw     = $clog2(hcmm_pkg::BOOT_SIZE);
  localparam logic [2:0] MaxBank = 3'(WRAM_BANKS);

  // Stage-1 control: what the RAM outputs mean next cycle
  typedef struct packed {
    hcmm_pkg::region_t rgn;
    logic              rd;
    logic              st;
    logic [7:0]        ie;
  } s1_t;

  // Control state
  logic             clr_busy_r;
  logic [RomAw-1:0] clr_cnt_r;
  logic             overlay_r;    // boot overlay active
  logic [2:0]       bank_r;       // copy of I/O 0x70 bits 2..0
  logic [7:0]       ie_r;
  logic             s1_v_r;
  logic             out_valid_r;

  // Payload
  s1_t        s1_r;
  logic [7:0] out_rd_r;
  logic       out_st_r;

  // Request decode
  hcmm_pkg::req_t    req;
  hcmm_pkg::region_t rgn;
  logic              acc;
  logic              s1_adv;
  logic              is_rd;
  logic              is_wr;
  logic              ld_rom;
  logic              ld_boot;
  logic              wr_ok;
  logic [2:0]        bank_eff;
  logic [2:0]        bank_m1;
  logic [14:0]       wramx_full;
  logic [WramxAw-1:0] wramx_addr;
  logic [6:0]        unus_off;
  logic [7:0]        rd_mux;
  s1_t               s1_nxt;

  // RAM read data
  logic [7:0] rom_q, boot_q, vram_q, eram_q, wram0_q, wramx_q;
  logic [7:0] oam_q, unus_q, io_q, hram_q;
  logic [7:0] ram_wd;

  assign s1_adv   = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_busy_r || (s1_v_r && !s1_adv);
  assign acc      = in_valid && !in_stall;

  assign req     = hcmm_pkg::req_t'(in_req_type);
  assign rgn     = hcmm_pkg::bus_region(in_address, overlay_r);
  assign is_rd   = acc && (req == hcmm_pkg::REQ_READ);
  assign is_wr   = acc && (req == hcmm_pkg::REQ_WRITE);
  assign ld_rom  = acc && (req == hcmm_pkg::REQ_LOAD_ROM)
                   && (in_address < 16'(hcmm_pkg::ROM_SIZE));
  assign ld_boot = acc && (req == hcmm_pkg::REQ_LOAD_BOOT)
                   && (in_address < 16'(hcmm_pkg::BOOT_SIZE));
  // bus write that lands in RAM space (ROM space rejects)
  assign wr_ok   = is_wr && (in_address >= hcmm_pkg::ADDR_RAM_BASE);

  // Bank select: 0 reads as 1, clamp to the last bank
  always_comb begin
    bank_eff = (bank_r == 3'd0) ? 3'd1 : bank_r;
    if (bank_eff > MaxBank) begin
      bank_eff = MaxBank;
    end
    bank_m1 = bank_eff - 3'd1;
  end
  assign wramx_full = {bank_m1, in_address[11:0]};
  assign wramx_addr = wramx_full[WramxAw-1:0];
  assign unus_off   = 7'(in_address[7:0] - hcmm_pkg::UNUS_OFFSET);

  // The clearing pass drives zeros through every write port
  assign ram_wd = clr_busy_r ? 8'h00 : in_write_data;

  hcmm_ram #(.Width(8), .Depth(hcmm_pkg::ROM_SIZE)) u_rom (
    .clk   (clk),
    .we    (clr_busy_r || ld_rom),
    .re    (is_rd && rgn == hcmm_pkg::RGN_ROM),
    .addr  (clr_busy_r ? clr_cnt_r : in_address[RomAw-1:0]),
    .wdata (ram_wd),
    .rdata (rom_q)
  );

  hcmm_ram #(.Width(8), .Depth(hcmm_pkg::BOOT_SIZE)) u_boot (
    .clk   (clk),
    .we    (clr_busy_r || ld_boot),
    .re    (is_rd && rgn == hcmm_pkg::RGN_BOOT),
    .addr  (clr_busy_r ? clr_cnt_r[BootAw-1:0] : in_address[BootAw-1:0]),
    .wdata (ram_wd),
    .rdata (boot_q)
  );

  hcmm_ram #(.Width(8), .Depth(8192)) u_vram (
    .clk   (clk),
    .we    (clr_busy_r || (wr_ok && rgn == hcmm_pkg::RGN_VRAM)),
    .re    (is_rd && rgn == hcmm_pkg::RGN_VRAM),
    .addr  (clr_busy_r ? clr_cnt_r[12:0] : in_address[12:0]),
    .wdata (ram_wd),
    .rdata (vram_q)
  );

  hcmm_ram #(.Width(8), .Depth(8192)) u_eram (
    .clk   (clk),
    .we    (clr_busy_r || (wr_ok && rgn == hcmm_pkg::RGN_ERAM)),
    .re    (is_rd && rgn == hcmm_pkg::RGN_ERAM),
    .addr  (clr_busy_r ? clr_cnt_r[12:0] : in_address[12:0]),
    .wdata (ram_wd),
    .rdata (eram_q)
  );

  hcmm_ram #(.Width(8), .Depth(hcmm_pkg::BANK_BYTES)) u_wram0 (
    .clk   (clk),
    .we    (clr_busy_r || (wr_ok && rgn == hcmm_pkg::RGN_WRAM0)),
    .re    (is_rd && rgn == hcmm_pkg::RGN_WRAM0),
    .addr  (clr_busy_r ? clr_cnt_r[11:0] : in_address[11:0]),
    .wdata (ram_wd),
    .rdata (wram0_q)
  );

  hcmm_ram #(.Width(8), .Depth(WramxDepth)) u_wramx (
    .clk   (clk),
    .we    (clr_busy_r || (wr_ok && rgn == hcmm_pkg::RGN_WRAMX)),
    .re    (is_rd && rgn == hcmm_pkg::RGN_WRAMX),
    .addr  (clr_busy_r ? clr_cnt_r[WramxAw-1:0] : wramx_addr),
    .wdata (ram_wd),
    .rdata (wramx_q)
  );

  hcmm_ram #(.Width(8), .Depth(160)) u_oam (
    .clk   (clk),
    .we    (clr_busy_r || (wr_ok && rgn == hcmm_pkg::RGN_OAM)),
    .re    (is_rd && rgn == hcmm_pkg::RGN_OAM),
    .addr  (clr_busy_r ? clr_cnt_r[7:0] : in_address[7:0]),
    .wdata (ram_wd),
    .rdata (oam_q)
  );

  hcmm_ram #(.Width(8), .Depth(96)) u_unus (
    .clk   (clk),
    .we    (clr_busy_r || (wr_ok && rgn == hcmm_pkg::RGN_UNUS)),
    .re    (is_rd && rgn == hcmm_pkg::RGN_UNUS),
    .addr  (clr_busy_r ? clr_cnt_r[6:0] : unus_off),
    .wdata (ram_wd),
    .rdata (unus_q)
  );

  hcmm_ram #(.Width(8), .Depth(128)) u_io (
    .clk   (clk),
    .we    (clr_busy_r || (wr_ok && rgn == hcmm_pkg::RGN_IO)),
    .re    (is_rd && rgn == hcmm_pkg::RGN_IO),
    .addr  (clr_busy_r ? clr_cnt_r[6:0] : in_address[6:0]),
    .wdata (ram_wd),
    .rdata (io_q)
  );

  hcmm_ram #(.Width(8), .Depth(127)) u_hram (
    .clk   (clk),
    .we    (clr_busy_r || (wr_ok && rgn == hcmm_pkg::RGN_HRAM)),
    .re    (is_rd && rgn == hcmm_pkg::RGN_HRAM),
    .addr  (clr_busy_r ? clr_cnt_r[6:0] : in_address[6:0]),
    .wdata (ram_wd),
    .rdata (hram_q)
  );

  always_comb begin
    s1_nxt.rgn = rgn;
    s1_nxt.rd  = is_rd;
    s1_nxt.st  = is_wr && (in_address < hcmm_pkg::ADDR_RAM_BASE);
    s1_nxt.ie  = ie_r;
  end

  // Region select on the registered RAM outputs
  always_comb begin
    case (s1_r.rgn)
      hcmm_pkg::RGN_BOOT:  rd_mux = boot_q;
      hcmm_pkg::RGN_ROM:   rd_mux = rom_q;
      hcmm_pkg::RGN_VRAM:  rd_mux = vram_q;
      hcmm_pkg::RGN_ERAM:  rd_mux = eram_q;
      hcmm_pkg::RGN_WRAM0: rd_mux = wram0_q;
      hcmm_pkg::RGN_WRAMX: rd_mux = wramx_q;
      hcmm_pkg::RGN_OAM:   rd_mux = oam_q;
      hcmm_pkg::RGN_UNUS:  rd_mux = unus_q;
      hcmm_pkg::RGN_IO:    rd_mux = io_q;
      hcmm_pkg::RGN_HRAM:  rd_mux = hram_q;
      hcmm_pkg::RGN_IE:    rd_mux = s1_r.ie;
      default:             rd_mux = 8'h00;
    endcase
    if (!s1_r.rd) begin
      rd_mux = 8'h00;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      overlay_r   <= 1'b1;
      bank_r      <= 3'd0;
      ie_r        <= 8'h00;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + RomAw'(1);
        if (clr_cnt_r == RomAw'(hcmm_pkg::ROM_SIZE - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      // side effects of bus writes
      if (is_wr) begin
        if (in_address == hcmm_pkg::ADDR_BOOT_OFF && in_write_data != 8'h00) begin
          overlay_r <= 1'b0;
        end
        if (in_address == hcmm_pkg::ADDR_WRAM_BANK) begin
          bank_r <= in_write_data[2:0];
        end
        if (in_address == hcmm_pkg::ADDR_IE) begin
          ie_r <= in_write_data;
        end
      end
      s1_v_r <= acc || (s1_v_r && !s1_adv);
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_rd_r <= rd_mux;
      out_st_r <= s1_r.st;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_status    = out_st_r;

endmodule

FILE: rtl/hcmm_ram.sv
// ----------------------------------------------------------------------------
// hcmm_ram: generic single-port RAM
// One address per cycle, write or registered read. Writes past Depth drop.
// ----------------------------------------------------------------------------
module hcmm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AddrW-1:0] addr,
  input  logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we && 32'(addr) < Depth) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/hcmm_checker.sv
// ----------------------------------------------------------------------------
// hcmm_checker: port-level checks for the memory map
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module hcmm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic       out_status
);

  // reset starts the clearing pass, so nothing is taken right after it
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("in_stall low right after reset");

  // a rising out_valid must have an accepted request beat behind it
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result beat with no request beat behind it");

  // a rejected ROM write returns no data
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_data == 8'h00)
    else $error("rejected write carries read data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped under stall");

endmodule

bind handheld_console_memory_map hcmm_checker u_hcmm_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for handheld_console_memory_map
// Sends bus reads, bus writes and image loads through the request channel.
// A behavioral copy of the memory map predicts each reply beat that a table
// row does not type in. Each reply is checked in order against its expected
// value, with random gaps on the request channel and stalls on the reply one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WRAM_BANKS   = 7;
  localparam int RAND_ITEMS   = 1480;
  localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
  localparam int HOLD_AFTER   = 300;     // replies seen before the hold-off
  localparam int DRAIN_CYCLES = 20;      // idle time after the last reply
  // Clearing pass plus 1.5k beats at worst-case gap and stall, x4.
  localparam int CYCLE_LIMIT  = 800000;

  // One request beat, plus an optional typed-in reply for table rows.
  typedef struct {
    hcmm_pkg::req_t req;
    logic [15:0]    addr;
    logic [7:0]     data;
    bit             fixed;
    logic [7:0]     rd;
    logic           st;
  } bus_beat_t;

  // One reply beat still owed by the block.
  typedef struct {
    hcmm_pkg::req_t req;
    logic [15:0]    addr;
    logic [7:0]     rd;
    logic           st;
  } reply_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type   = 2'b00;
  logic [15:0] in_address    = 16'h0000;
  logic [7:0]  in_write_data = 8'h00;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_status;

  handheld_console_memory_map #(.WRAM_BANKS(WRAM_BANKS)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_status    (out_status)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow memory map: same stores as the block, updated at request accept.
  // --------------------------------------------------------------------------
  logic       overlay_on;
  logic [7:0] boot_mem  [0:hcmm_pkg::BOOT_SIZE-1];
  logic [7:0] rom_mem   [0:hcmm_pkg::ROM_SIZE-1];
  logic [7:0] vram_mem  [0:8191];
  logic [7:0] eram_mem  [0:8191];
  logic [7:0] wram0_mem [0:hcmm_pkg::BANK_BYTES-1];
  logic [7:0] wramx_mem [0:WRAM_BANKS*hcmm_pkg::BANK_BYTES-1];
  logic [7:0] oam_mem   [0:159];
  logic [7:0] unus_mem  [0:95];
  logic [7:0] io_mem    [0:127];
  logic [7:0] hram_mem  [0:126];
  logic [7:0] ie_reg;

  reply_t      replies_due [$];   // predicted replies, oldest first
  logic [15:0] recent [$];        // last written/loaded addresses, for readback
  bit          quiet;             // no gaps, and no stalls outside the hold-off, while set
  int          mismatches   = 0;
  int          replies_seen = 0;
  int          rom_rejects  = 0;
  int          beats_by_req [4];
  int          cycle_count  = 0;

  // Read or write one byte on the RAM side (0x8000 and up). Echo space folds
  // 0x2000 down; the banked work RAM follows bits 2..0 of the bank register,
  // with bank 0 read as bank 1.
  task automatic ram_access(input logic [15:0] a, input bit wr, input logic [7:0] d,
                            output logic [7:0] q);
    logic [15:0] f;
    int          bank;
    int          i;
    f = (a >= hcmm_pkg::ADDR_ECHO_BASE && a < hcmm_pkg::ADDR_OAM_BASE)
        ? a - hcmm_pkg::ADDR_ECHO_SHIFT : a;
    bank = int'(io_mem[hcmm_pkg::ADDR_WRAM_BANK - hcmm_pkg::ADDR_IO_BASE][2:0]);
    if (bank == 0) bank = 1;
    if (bank > WRAM_BANKS) bank = WRAM_BANKS;
    if (f < hcmm_pkg::ADDR_ERAM_BASE) begin
      i = int'(f - hcmm_pkg::ADDR_RAM_BASE);
      q = vram_mem[i];
      if (wr) vram_mem[i] = d;
    end else if (f < hcmm_pkg::ADDR_WRAM0_BASE) begin
      i = int'(f - hcmm_pkg::ADDR_ERAM_BASE);
      q = eram_mem[i];
      if (wr) eram_mem[i] = d;
    end else if (f < hcmm_pkg::ADDR_WRAMX_BASE) begin
      i = int'(f - hcmm_pkg::ADDR_WRAM0_BASE);
      q = wram0_mem[i];
      if (wr) wram0_mem[i] = d;
    end else if (f < hcmm_pkg::ADDR_ECHO_BASE) begin
      i = (bank - 1) * hcmm_pkg::BANK_BYTES + int'(f - hcmm_pkg::ADDR_WRAMX_BASE);
      q = wramx_mem[i];
      if (wr) wramx_mem[i] = d;
    end else if (f < hcmm_pkg::ADDR_UNUS_BASE) begin
      i = int'(f - hcmm_pkg::ADDR_OAM_BASE);
      q = oam_mem[i];
      if (wr) oam_mem[i] = d;
    end else if (f < hcmm_pkg::ADDR_IO_BASE) begin
      i = int'(f - hcmm_pkg::ADDR_UNUS_BASE);
      q = unus_mem[i];
      if (wr) unus_mem[i] = d;
    end else if (f < hcmm_pkg::ADDR_HRAM_BASE) begin
      i = int'(f - hcmm_pkg::ADDR_IO_BASE);
      q = io_mem[i];
      if (wr) io_mem[i] = d;
    end else if (f < hcmm_pkg::ADDR_IE) begin
      i = int'(f - hcmm_pkg::ADDR_HRAM_BASE);
      q = hram_mem[i];
      if (wr) hram_mem[i] = d;
    end else begin
      q = ie_reg;
      if (wr) ie_reg = d;
    end
  endtask

  // Reply to one request and apply its side effects to the shadow map.
  task automatic predict_bus(input hcmm_pkg::req_t r, input logic [15:0] a,
                             input logic [7:0] d, output logic [7:0] rd, output logic st);
    logic [7:0] dummy;
    rd = 8'h00;
    st = 1'b0;
    case (r)
      hcmm_pkg::REQ_READ: begin
        if (a >= hcmm_pkg::ADDR_RAM_BASE) ram_access(a, 1'b0, d, rd);
        else if (overlay_on && int'(a) < hcmm_pkg::BOOT_SIZE) rd = boot_mem[a[7:0]];
        else rd = rom_mem[a[14:0]];
      end
      hcmm_pkg::REQ_WRITE: begin
        // ROM writes bounce with status set and change nothing
        if (a < hcmm_pkg::ADDR_RAM_BASE) begin
          st = 1'b1;
        end else begin
          // any nonzero byte at the boot-off register drops the overlay for good
          if (a == hcmm_pkg::ADDR_BOOT_OFF && d != 8'h00) overlay_on = 1'b0;
          ram_access(a, 1'b1, d, dummy);
        end
      end
      hcmm_pkg::REQ_LOAD_ROM: begin
        if (int'(a) < hcmm_pkg::ROM_SIZE) rom_mem[a[14:0]] = d;
      end
      default: begin
        if (int'(a) < hcmm_pkg::BOOT_SIZE) boot_mem[a[7:0]] = d;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic bus_beat_t mk(input hcmm_pkg::req_t r, input logic [15:0] a,
                                   input logic [7:0] d, input bit fixed = 1'b0,
                                   input logic [7:0] rd = 8'h00, input logic st = 1'b0);
    bus_beat_t b;
    b.req   = r;
    b.addr  = a;
    b.data  = d;
    b.fixed = fixed;
    b.rd    = rd;
    b.st    = st;
    return b;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random request. Addresses lean on region edges, the bank register, the
  // high page, the boot window and readback of recently touched bytes.
  // Before the overlay is dropped on purpose, writes to the boot-off register
  // carry zero so the boot image stays visible.
  function automatic bus_beat_t rand_beat(input bit overlay_may_drop);
    bus_beat_t   b;
    logic [15:0] base;
    int          r;
    b = mk(hcmm_pkg::REQ_READ, 16'h0000, 8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 40) b.req = hcmm_pkg::REQ_READ;
    else if (r < 75) b.req = hcmm_pkg::REQ_WRITE;
    else if (r < 90) b.req = hcmm_pkg::REQ_LOAD_ROM;
    else b.req = hcmm_pkg::REQ_LOAD_BOOT;

    r = $urandom_range(0, 99);
    if (b.req == hcmm_pkg::REQ_LOAD_ROM) begin
      if (r < 50) b.addr = 16'($urandom_range(0, 1023));
      else if (r < 92) b.addr = 16'($urandom_range(0, hcmm_pkg::ROM_SIZE - 1));
      else b.addr = 16'($urandom);
    end else if (b.req == hcmm_pkg::REQ_LOAD_BOOT) begin
      if (r < 90) b.addr = 16'($urandom_range(0, hcmm_pkg::BOOT_SIZE - 1));
      else b.addr = 16'($urandom);
    end else if (r < 25 && recent.size() > 0) begin
      b.addr = recent[$urandom_range(0, recent.size() - 1)];
      // sometimes hit the same byte through its echo alias
      if ($urandom_range(0, 2) == 0) begin
        if (b.addr >= hcmm_pkg::ADDR_WRAM0_BASE &&
            b.addr < hcmm_pkg::ADDR_OAM_BASE - hcmm_pkg::ADDR_ECHO_SHIFT)
          b.addr = b.addr + hcmm_pkg::ADDR_ECHO_SHIFT;
        else if (b.addr >= hcmm_pkg::ADDR_ECHO_BASE && b.addr < hcmm_pkg::ADDR_OAM_BASE)
          b.addr = b.addr - hcmm_pkg::ADDR_ECHO_SHIFT;
      end
    end else if (r < 37) begin
      case ($urandom_range(0, 11))
        0:       base = 16'h0000;
        1:       base = 16'(hcmm_pkg::BOOT_SIZE);
        2:       base = hcmm_pkg::ADDR_RAM_BASE;
        3:       base = hcmm_pkg::ADDR_ERAM_BASE;
        4:       base = hcmm_pkg::ADDR_WRAM0_BASE;
        5:       base = hcmm_pkg::ADDR_WRAMX_BASE;
        6:       base = hcmm_pkg::ADDR_ECHO_BASE;
        7:       base = hcmm_pkg::ADDR_OAM_BASE;
        8:       base = hcmm_pkg::ADDR_UNUS_BASE;
        9:       base = hcmm_pkg::ADDR_IO_BASE;
        10:      base = hcmm_pkg::ADDR_HRAM_BASE;
        default: base = hcmm_pkg::ADDR_IE;
      endcase
      b.addr = ($urandom_range(0, 1) == 0) ? base : base - 16'h0001;
    end else if (r < 45) begin
      b.addr = hcmm_pkg::ADDR_WRAM_BANK;
    end else if (r < 60) begin
      b.addr = 16'($urandom_range(hcmm_pkg::ADDR_OAM_BASE, hcmm_pkg::ADDR_IE));
    end else if (r < 72) begin
      b.addr = 16'($urandom_range(0, hcmm_pkg::BOOT_SIZE - 1));
    end else begin
      b.addr = 16'($urandom);
    end

    if (b.req == hcmm_pkg::REQ_WRITE && b.addr == hcmm_pkg::ADDR_BOOT_OFF &&
        !overlay_may_drop) b.data = 8'h00;
    return b;
  endfunction

  // Offer one beat, hold it until accepted, then predict its reply. Valid is
  // left high on return so a back-to-back beat never toggles it.
  task automatic send_beat(input bus_beat_t b);
    int         gap;
    logic [7:0] rd;
    logic       st;
    reply_t     due;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= b.req;
    in_address    <= b.addr;
    in_write_data <= b.data;
    do @(posedge clk); while (!(in_valid && !in_stall));

    predict_bus(b.req, b.addr, b.data, rd, st);
    if (b.fixed) begin
      rd = b.rd;
      st = b.st;
    end
    due.req  = b.req;
    due.addr = b.addr;
    due.rd   = rd;
    due.st   = st;
    replies_due.push_back(due);
    beats_by_req[int'(b.req)]++;
    if (b.req != hcmm_pkg::REQ_READ) begin
      recent.push_back(b.addr);
      if (recent.size() > 16) recent.delete(0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Reply side: random stall runs, one long hold-off while requests keep
  // coming, so the pipeline backs up into in_stall.
  // --------------------------------------------------------------------------
  initial begin : reply_stall
    int run_left;
    int hold_left;
    int r;
    bit held;
    run_left  = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && replies_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(0, 15);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          run_left = $urandom_range(10, 40);
        end
      end
    end
  end

  task automatic flag_mismatch(input string what, input reply_t r, input int got,
                               input int want);
    mismatches++;
    $display("%0t ns: %s on %s @%h: got %h, want %h", $time, what, r.req.name(), r.addr,
             got, want);
  endtask

  // Sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin : reply_check
    reply_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      replies_seen++;
      if (out_status === 1'b1) rom_rejects++;
      if (replies_due.size() == 0) begin
        exp_r.req  = hcmm_pkg::REQ_READ;
        exp_r.addr = 16'h0000;
        flag_mismatch("reply with nothing pending", exp_r, out_read_data, 0);
      end else begin
        exp_r = replies_due.pop_front();
        if (out_read_data !== exp_r.rd)
          flag_mismatch("read_data", exp_r, out_read_data, exp_r.rd);
        if (out_status !== exp_r.st)
          flag_mismatch("status", exp_r, out_status, exp_r.st);
      end
    end
  end

  // Watchdog; the limit covers the post-reset clearing pass.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count,
               replies_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    bus_beat_t tab [$];
    int        k;
    overlay_on = 1'b1;
    ie_reg     = 8'h00;
    foreach (boot_mem[n])  boot_mem[n]  = 8'h00;
    foreach (rom_mem[n])   rom_mem[n]   = 8'h00;
    foreach (vram_mem[n])  vram_mem[n]  = 8'h00;
    foreach (eram_mem[n])  eram_mem[n]  = 8'h00;
    foreach (wram0_mem[n]) wram0_mem[n] = 8'h00;
    foreach (wramx_mem[n]) wramx_mem[n] = 8'h00;
    foreach (oam_mem[n])   oam_mem[n]   = 8'h00;
    foreach (unus_mem[n])  unus_mem[n]  = 8'h00;
    foreach (io_mem[n])    io_mem[n]    = 8'h00;
    foreach (hram_mem[n])  hram_mem[n]  = 8'h00;
    foreach (beats_by_req[n]) beats_by_req[n] = 0;
    quiet = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows. Typed replies: cleared stores, ROM write bounces,
    // out-of-range loads. The rest go through the shadow map.
    tab.push_back(mk(hcmm_pkg::REQ_READ,      16'h0000, 8'h00, 1'b1, 8'h00, 1'b0));
    tab.push_back(mk(hcmm_pkg::REQ_READ,      hcmm_pkg::ADDR_IE, 8'hFF, 1'b1, 8'h00,
                     1'b0));
    tab.push_back(mk(hcmm_pkg::REQ_WRITE,     16'h0000, 8'hFF, 1'b1, 8'h00, 1'b1));
    tab.push_back(mk(hcmm_pkg::REQ_WRITE,     16'h7FFF, 8'h01, 1'b1, 8'h00, 1'b1));
    tab.push_back(mk(hcmm_pkg::REQ_LOAD_BOOT, 16'h0000, 8'hA5));
    tab.push_back(mk(hcmm_pkg::REQ_LOAD_BOOT, 16'h00FF, 8'hFF));
    tab.push_back(mk(hcmm_pkg::REQ_LOAD_BOOT, 16'h0100, 8'h11, 1'b1, 8'h00, 1'b0));
    tab.push_back(mk(hcmm_pkg::REQ_LOAD_ROM,  16'h0000, 8'h3C));
    tab.push_back(mk(hcmm_pkg::REQ_LOAD_ROM,  16'h7FFF, 8'h80));
    tab.push_back(mk(hcmm_pkg::REQ_LOAD_ROM,  16'hFFFF, 8'h55, 1'b1, 8'h00, 1'b0));
    tab.push_back(mk(hcmm_pkg::REQ_READ,      16'h0000, 8'h00));   // boot overlay
    tab.push_back(mk(hcmm_pkg::REQ_READ,      16'h00FF, 8'h00));
    tab.push_back(mk(hcmm_pkg::REQ_READ,      16'h7FFF, 8'h00));   // ROM top
    tab.push_back(mk(hcmm_pkg::REQ_WRITE,     16'hC123, 8'h5A));
    tab.push_back(mk(hcmm_pkg::REQ_READ,      16'hE123, 8'h00));   // echo alias
    tab.push_back(mk(hcmm_pkg::REQ_WRITE,     hcmm_pkg::ADDR_WRAM_BANK,  8'h00));  // 0 -> 1
    tab.push_back(mk(hcmm_pkg::REQ_WRITE,     hcmm_pkg::ADDR_WRAMX_BASE, 8'h77));
    tab.push_back(mk(hcmm_pkg::REQ_WRITE,     hcmm_pkg::ADDR_WRAM_BANK,  8'hFF));  // top
    tab.push_back(mk(hcmm_pkg::REQ_WRITE,     16'hDDFF, 8'h99));
    tab.push_back(mk(hcmm_pkg::REQ_READ,      16'hFDFF, 8'h00));   // echo top
    tab.push_back(mk(hcmm_pkg::REQ_READ,      hcmm_pkg::ADDR_WRAMX_BASE, 8'h00));
    tab.push_back(mk(hcmm_pkg::REQ_WRITE,     hcmm_pkg::ADDR_WRAM_BANK,  8'h01));
    tab.push_back(mk(hcmm_pkg::REQ_READ,      hcmm_pkg::ADDR_WRAMX_BASE, 8'h00));  // bank 1
    tab.push_back(mk(hcmm_pkg::REQ_WRITE,     hcmm_pkg::ADDR_BOOT_OFF,   8'h00));  // kept
    tab.push_back(mk(hcmm_pkg::REQ_WRITE,     hcmm_pkg::ADDR_IE,         8'hFF));
    tab.push_back(mk(hcmm_pkg::REQ_READ,      hcmm_pkg::ADDR_IE,         8'h00));
    foreach (tab[i]) send_beat(tab[i]);

    // Random traffic. Every fourth block of 128 beats runs with no idling.
    // Halfway through, the sender drains, then drops the boot overlay.
    for (k = 0; k < RAND_ITEMS; k++) begin
      quiet = ((k / 128) % 4) == 3;
      if (k == RAND_ITEMS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (replies_due.size() != 0) @(posedge clk);
        send_beat(mk(hcmm_pkg::REQ_WRITE, hcmm_pkg::ADDR_BOOT_OFF,
                     8'($urandom_range(1, 255)), 1'b1, 8'h00, 1'b0));
        send_beat(mk(hcmm_pkg::REQ_READ, 16'h0000, 8'h00));
      end
      send_beat(rand_beat(k >= RAND_ITEMS / 2));
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d replies: %0d reads, %0d writes (%0d ROM bounces), %0d ROM loads,",
             replies_seen, beats_by_req[0], beats_by_req[1], rom_rejects, beats_by_req[2]);
    $display("%0d boot loads; overlay dropped mid-run, one %0d-cycle reply hold-off.",
             beats_by_req[3], LONG_HOLD);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/hcmm_pkg.sv
rtl/hcmm_ram.sv
rtl/handheld_console_memory_map.sv
rtl/hcmm_checker.sv
dv/tb_top.sv
